@@ sv/mtsed_pkg.sv @@
// ----------------------------------------------------------------------------
// mtsed_pkg
// Shared types, byte constants and held-text tables for the tag stripper.
// ----------------------------------------------------------------------------
package mtsed_pkg;

    // Input item: one byte of the message plus its end flag.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_message;
    } t_in_item;

    // Result item.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       last_of_message;
    } t_out_item;

    // Entity match progress.
    typedef logic [3:0] t_prog;

    localparam t_prog PROG_NONE    = 4'd0;
    localparam t_prog PROG_AMP     = 4'd1;  // "&"
    localparam t_prog PROG_AMP_L   = 4'd2;  // "&l"
    localparam t_prog PROG_LT      = 4'd3;  // "&lt"
    localparam t_prog PROG_AMP_G   = 4'd4;  // "&g"
    localparam t_prog PROG_GT      = 4'd5;  // "&gt"
    localparam t_prog PROG_AMP_A   = 4'd6;  // "&a"
    localparam t_prog PROG_AMP_AM  = 4'd7;  // "&am"
    localparam t_prog PROG_AMP_AMP = 4'd8;  // "&amp"
    localparam t_prog PROG_DONE    = 4'd15; // entity completed

    localparam logic [7:0] C_LT   = 8'h3C; // '<'
    localparam logic [7:0] C_GT   = 8'h3E; // '>'
    localparam logic [7:0] C_AMP  = 8'h26; // '&'
    localparam logic [7:0] C_SEMI = 8'h3B; // ';'
    localparam logic [7:0] C_L    = 8'h6C; // 'l'
    localparam logic [7:0] C_G    = 8'h67; // 'g'
    localparam logic [7:0] C_A    = 8'h61; // 'a'
    localparam logic [7:0] C_T    = 8'h74; // 't'
    localparam logic [7:0] C_M    = 8'h6D; // 'm'
    localparam logic [7:0] C_P    = 8'h70; // 'p'

    // Command passed from the classifier to the result sequencer.
    // Order of results: held text rel_first, then mid byte, then held text rel_end.
    typedef struct packed {
        t_prog      rel_first;  // held text released on a broken match
        logic       has_mid;
        logic [7:0] mid_byte;   // literal or decoded byte
        t_prog      rel_end;    // held text flushed at message end
        logic       eom;
    } t_cmd;

    // Number of bytes held for a progress code.
    function automatic logic [2:0] held_len(input t_prog p);
        logic [2:0] len;
        unique case (p)
            PROG_AMP:                          len = 3'd1;
            PROG_AMP_L, PROG_AMP_G, PROG_AMP_A: len = 3'd2;
            PROG_LT, PROG_GT, PROG_AMP_AM:     len = 3'd3;
            PROG_AMP_AMP:                      len = 3'd4;
            default:                           len = 3'd0;
        endcase
        return len;
    endfunction

    // Byte k of the held text for a progress code.
    function automatic logic [7:0] held_char(input t_prog p, input logic [1:0] k);
        logic [7:0] ch;
        unique case (k)
            2'd0: ch = C_AMP;
            2'd1: begin
                if (p == PROG_AMP_L || p == PROG_LT) begin
                    ch = C_L;
                end else if (p == PROG_AMP_G || p == PROG_GT) begin
                    ch = C_G;
                end else begin
                    ch = C_A;
                end
            end
            2'd2: ch = (p == PROG_LT || p == PROG_GT) ? C_T : C_M;
            default: ch = C_P;
        endcase
        return ch;
    endfunction

endpackage

@@ sv/mtsed_front.sv @@
// ----------------------------------------------------------------------------
// mtsed_front
// Classifier: tracks tag and entity state, turns each item into a command.
// ----------------------------------------------------------------------------
module mtsed_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  mtsed_pkg::t_in_item i_in_item,
    input  logic                i_full,
    output logic                o_push,
    output mtsed_pkg::t_cmd     o_cmd
);

    logic             r_tag;
    mtsed_pkg::t_prog r_prog;
    logic             n_tag;
    mtsed_pkg::t_prog n_prog;

    logic             accept;
    logic             held;
    logic             handle;
    logic             tag_mid;
    mtsed_pkg::t_prog prog_mid;
    mtsed_pkg::t_prog nxt;
    logic [7:0]       b;

    // Next progress, PROG_DONE on a completed entity, PROG_NONE on a break.
    function automatic mtsed_pkg::t_prog advance(input mtsed_pkg::t_prog p,
                                                 input logic [7:0] c);
        mtsed_pkg::t_prog r;
        r = mtsed_pkg::PROG_NONE;
        unique case (p)
            mtsed_pkg::PROG_AMP: begin
                if (c == mtsed_pkg::C_L) begin
                    r = mtsed_pkg::PROG_AMP_L;
                end else if (c == mtsed_pkg::C_G) begin
                    r = mtsed_pkg::PROG_AMP_G;
                end else if (c == mtsed_pkg::C_A) begin
                    r = mtsed_pkg::PROG_AMP_A;
                end
            end
            mtsed_pkg::PROG_AMP_L:
                if (c == mtsed_pkg::C_T) r = mtsed_pkg::PROG_LT;
            mtsed_pkg::PROG_AMP_G:
                if (c == mtsed_pkg::C_T) r = mtsed_pkg::PROG_GT;
            mtsed_pkg::PROG_AMP_A:
                if (c == mtsed_pkg::C_M) r = mtsed_pkg::PROG_AMP_AM;
            mtsed_pkg::PROG_AMP_AM:
                if (c == mtsed_pkg::C_P) r = mtsed_pkg::PROG_AMP_AMP;
            mtsed_pkg::PROG_LT, mtsed_pkg::PROG_GT, mtsed_pkg::PROG_AMP_AMP:
                if (c == mtsed_pkg::C_SEMI) r = mtsed_pkg::PROG_DONE;
            default: r = mtsed_pkg::PROG_NONE;
        endcase
        return r;
    endfunction

    assign o_in_ready = !i_full;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        b        = i_in_item.in_byte;
        held     = (r_prog >= mtsed_pkg::PROG_AMP) && (r_prog <= mtsed_pkg::PROG_AMP_AMP);
        nxt      = advance(r_prog, b);
        handle   = 1'b1;
        tag_mid  = r_tag;
        prog_mid = mtsed_pkg::PROG_NONE;

        o_cmd.rel_first = mtsed_pkg::PROG_NONE;
        o_cmd.has_mid   = 1'b0;
        o_cmd.mid_byte  = b;
        o_cmd.rel_end   = mtsed_pkg::PROG_NONE;
        o_cmd.eom       = i_in_item.end_of_message;

        if (held) begin
            if (nxt == mtsed_pkg::PROG_DONE) begin
                handle         = 1'b0;
                o_cmd.has_mid  = 1'b1;
                o_cmd.mid_byte = (r_prog == mtsed_pkg::PROG_LT) ? mtsed_pkg::C_LT :
                                 (r_prog == mtsed_pkg::PROG_GT) ? mtsed_pkg::C_GT :
                                 mtsed_pkg::C_AMP;
            end else if (nxt != mtsed_pkg::PROG_NONE) begin
                handle   = 1'b0;
                prog_mid = nxt;
            end else if (!r_tag) begin
                // Broken match outside a tag: release held text as literal.
                o_cmd.rel_first = r_prog;
            end
        end

        if (handle) begin
            priority if (b == mtsed_pkg::C_LT) begin
                tag_mid = 1'b1;
            end else if (b == mtsed_pkg::C_GT) begin
                tag_mid = 1'b0;
            end else if (b == mtsed_pkg::C_AMP) begin
                prog_mid = mtsed_pkg::PROG_AMP;
            end else if (!r_tag) begin
                o_cmd.has_mid = 1'b1;
            end
        end

        n_tag  = tag_mid;
        n_prog = prog_mid;
        if (i_in_item.end_of_message) begin
            // Flush what is still held, then clear the state.
            if (!tag_mid) begin
                o_cmd.rel_end = prog_mid;
            end
            n_tag  = 1'b0;
            n_prog = mtsed_pkg::PROG_NONE;
        end

        o_push = accept && (o_cmd.rel_first != mtsed_pkg::PROG_NONE || o_cmd.has_mid
                            || o_cmd.rel_end != mtsed_pkg::PROG_NONE || o_cmd.eom);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag  <= 1'b0;
            r_prog <= mtsed_pkg::PROG_NONE;
        end else if (accept) begin
            r_tag  <= n_tag;
            r_prog <= n_prog;
        end
    end

`ifndef ASSERT_OFF
    a_eom_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in_item.end_of_message |=> !r_tag && r_prog == mtsed_pkg::PROG_NONE)
        else $error("state not cleared after message end");
    a_prog_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prog <= mtsed_pkg::PROG_AMP_AMP)
        else $error("entity progress out of range");
`endif

endmodule

@@ sv/mtsed_queue.sv @@
// ----------------------------------------------------------------------------
// mtsed_queue
// Small command FIFO between the classifier and the result sequencer.
// ----------------------------------------------------------------------------
module mtsed_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mtsed_pkg::t_cmd i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output mtsed_pkg::t_cmd o_data
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    mtsed_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");
`endif

endmodule

@@ sv/mtsed_back.sv @@
// ----------------------------------------------------------------------------
// mtsed_back
// Result sequencer: expands one command into its result items, one a cycle while the receiver takes them.
// ----------------------------------------------------------------------------
module mtsed_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_empty,
    input  mtsed_pkg::t_cmd      i_cmd,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output mtsed_pkg::t_out_item o_out_item
);

    logic                 r_valid;
    mtsed_pkg::t_out_item r_item;
    logic [2:0]           r_idx;
    logic [2:0]           n_idx;

    logic                 load;
    logic [3:0]           len1;
    logic [3:0]           len2;
    logic [3:0]           mid;
    logic [3:0]           total;
    logic [3:0]           idx;
    logic [3:0]           k2;
    logic                 bare;
    logic                 is_end;
    logic [7:0]           cur_byte;
    mtsed_pkg::t_out_item n_item;

    assign load = !i_empty && (!r_valid || i_out_ready);

    always_comb begin
        len1   = {1'b0, mtsed_pkg::held_len(i_cmd.rel_first)};
        len2   = {1'b0, mtsed_pkg::held_len(i_cmd.rel_end)};
        mid    = {3'b000, i_cmd.has_mid};
        total  = len1 + mid + len2;
        idx    = {1'b0, r_idx};
        k2     = idx - len1 - mid;
        bare   = (total == 4'd0);
        is_end = bare || (idx == total - 4'd1);

        if (idx < len1) begin
            cur_byte = mtsed_pkg::held_char(i_cmd.rel_first, r_idx[1:0]);
        end else if (i_cmd.has_mid && idx == len1) begin
            cur_byte = i_cmd.mid_byte;
        end else begin
            cur_byte = mtsed_pkg::held_char(i_cmd.rel_end, k2[1:0]);
        end

        n_item.out_byte        = bare ? 8'h00 : cur_byte;
        n_item.has_byte        = !bare;
        n_item.last_of_message = i_cmd.eom && is_end;

        o_pop = load && is_end;
        n_idx = is_end ? 3'd0 : r_idx + 3'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 3'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= n_idx;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= n_item;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_item  = r_item;

`ifndef ASSERT_OFF
    a_bare_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.has_byte |-> o_out_item.last_of_message)
        else $error("bare marker without end flag");
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= 3'd4)
        else $error("result index beyond five results");
`endif

endmodule

@@ sv/markup_tag_stripper_entity_decoder.sv @@
// ----------------------------------------------------------------------------
// markup_tag_stripper_entity_decoder
// Strips markup tags and decodes &lt; &gt; &amp; from a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_item) takes one message byte
//   per item, with end_of_message on the final byte. Output channel
//   (o_out_valid / i_out_ready / o_out_item) gives zero to five result items
//   per input item, in order; a message end with nothing left to emit yields
//   one bare marker (has_byte 0, last_of_message 1).
//   The classifier writes the command queue when the item is accepted, and
//   the sequencer then loads the output register from the queue, which a
//   stalled receiver can hold off.
//   Throughput: one input item per cycle while each item yields at most one
//   result and the receiver is ready; the sequencer emits one result per
//   cycle while the receiver takes it, so an item that releases held entity
//   text backs up the command queue, which then lowers o_in_ready.
//   Items that produce nothing (dropped tag bytes, held entity prefixes)
//   never reach the queue and cost no output cycle.
//   Reset clears the tag and entity state, empties the queue and drops any
//   pending result. When the receiver stalls, the output register holds its
//   item, the queue fills, and then input is held off.
// ----------------------------------------------------------------------------
module markup_tag_stripper_entity_decoder #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  mtsed_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output mtsed_pkg::t_out_item o_out_item
);

    // Command path between the classifier and the sequencer.
    logic            push;
    logic            pop;
    logic            full;
    logic            empty;
    mtsed_pkg::t_cmd cmd_in;
    mtsed_pkg::t_cmd cmd_out;

    // Classify each byte and track tag/entity state.
    mtsed_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_full     (full),
        .o_push     (push),
        .o_cmd      (cmd_in)
    );

    // Decouple the two sides so each can stall on its own.
    mtsed_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (cmd_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (cmd_out)
    );

    // Expand commands into result items.
    mtsed_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_cmd       (cmd_out),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

@@ tb/tb_markup_tag_stripper_entity_decoder.sv @@
// ----------------------------------------------------------------------------
// tb_markup_tag_stripper_entity_decoder
// Self-checking testbench for the markup tag stripper and entity decoder.
// A directed part walks through tags, entities, broken and unfinished
// entities and message ends. Random messages built from text, tag and entity
// fragments follow, under three sender/receiver idle mixes and one full
// drain pause. Every result is checked against an in-testbench prediction.
// ----------------------------------------------------------------------------
module tb_markup_tag_stripper_entity_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_SHOWN   = 10;
    localparam int DRAIN_SLACK = 8;     // cycles to let the pipeline settle
    localparam int N_PHASE     = 76;    // random items per idle mix

    // DUT inputs, all known from time zero
    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    mtsed_pkg::t_in_item  i_in_item  = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    mtsed_pkg::t_out_item o_out_item;

    // Predictor state: mirrors the tag flag and the held entity prefix
    logic             tag_open  = 1'b0;
    mtsed_pkg::t_prog held_prog = mtsed_pkg::PROG_NONE;

    // Results predicted for one item, then the queue of results still due
    mtsed_pkg::t_out_item step_res[$];
    mtsed_pkg::t_out_item text_due[$];
    mtsed_pkg::t_out_item want;

    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int items_sent    = 0;
    int messages_sent = 0;
    int results_seen  = 0;
    int mismatches    = 0;

    markup_tag_stripper_entity_decoder uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    always #5 i_clk = ~i_clk;

    // Hard stop in case the block hangs or drops results
    initial begin
        #2_000_000;
        $display("timeout: %0d results still due", text_due.size());
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic mtsed_pkg::t_out_item make_result(logic [7:0] b, logic has,
                                                         logic last);
        mtsed_pkg::t_out_item r;
        r.out_byte        = b;
        r.has_byte        = has;
        r.last_of_message = last;
        return r;
    endfunction

    function automatic mtsed_pkg::t_in_item make_item(logic [7:0] b, logic eom);
        mtsed_pkg::t_in_item it;
        it.in_byte        = b;
        it.end_of_message = eom;
        return it;
    endfunction

    // Match progress after one more byte; DONE on a full entity, NONE on a break
    function automatic mtsed_pkg::t_prog next_prog(mtsed_pkg::t_prog p, logic [7:0] b);
        case (p)
            mtsed_pkg::PROG_AMP:
                return (b == mtsed_pkg::C_L) ? mtsed_pkg::PROG_AMP_L :
                       (b == mtsed_pkg::C_G) ? mtsed_pkg::PROG_AMP_G :
                       (b == mtsed_pkg::C_A) ? mtsed_pkg::PROG_AMP_A : mtsed_pkg::PROG_NONE;
            mtsed_pkg::PROG_AMP_L,
            mtsed_pkg::PROG_AMP_G:
                return (b == mtsed_pkg::C_T) ?
                       ((p == mtsed_pkg::PROG_AMP_L) ? mtsed_pkg::PROG_LT : mtsed_pkg::PROG_GT)
                       : mtsed_pkg::PROG_NONE;
            mtsed_pkg::PROG_AMP_A:
                return (b == mtsed_pkg::C_M) ? mtsed_pkg::PROG_AMP_AM : mtsed_pkg::PROG_NONE;
            mtsed_pkg::PROG_AMP_AM:
                return (b == mtsed_pkg::C_P) ? mtsed_pkg::PROG_AMP_AMP : mtsed_pkg::PROG_NONE;
            mtsed_pkg::PROG_LT,
            mtsed_pkg::PROG_GT,
            mtsed_pkg::PROG_AMP_AMP:
                return (b == mtsed_pkg::C_SEMI) ? mtsed_pkg::PROG_DONE : mtsed_pkg::PROG_NONE;
            default:
                return mtsed_pkg::PROG_NONE;
        endcase
    endfunction

    // Literal text behind each progress code
    function automatic string prefix_text(mtsed_pkg::t_prog p);
        case (p)
            mtsed_pkg::PROG_AMP:     return "&";
            mtsed_pkg::PROG_AMP_L:   return "&l";
            mtsed_pkg::PROG_LT:      return "&lt";
            mtsed_pkg::PROG_AMP_G:   return "&g";
            mtsed_pkg::PROG_GT:      return "&gt";
            mtsed_pkg::PROG_AMP_A:   return "&a";
            mtsed_pkg::PROG_AMP_AM:  return "&am";
            mtsed_pkg::PROG_AMP_AMP: return "&amp";
            default:                 return "";
        endcase
    endfunction

    // Release held bytes as literal text; dropped when inside a tag
    task automatic release_prefix();
        string s;
        int    k;
        s = prefix_text(held_prog);
        if (!tag_open) begin
            for (k = 0; k < s.len(); k++)
                step_res.push_back(make_result(s[k], 1'b1, 1'b0));
        end
        held_prog = mtsed_pkg::PROG_NONE;
    endtask

    // Work out every result one accepted item causes and queue them as due
    task automatic strip_decode_item(mtsed_pkg::t_in_item it);
        mtsed_pkg::t_prog     nxt;
        bit                   taken;
        mtsed_pkg::t_out_item tail;
        logic [7:0]           dec;
        taken = 0;
        step_res.delete();
        if (held_prog >= mtsed_pkg::PROG_AMP && held_prog <= mtsed_pkg::PROG_AMP_AMP) begin
            nxt = next_prog(held_prog, it.in_byte);
            if (nxt == mtsed_pkg::PROG_DONE) begin
                // a full entity decodes even inside a tag
                dec = (held_prog == mtsed_pkg::PROG_LT) ? mtsed_pkg::C_LT :
                      (held_prog == mtsed_pkg::PROG_GT) ? mtsed_pkg::C_GT : mtsed_pkg::C_AMP;
                step_res.push_back(make_result(dec, 1'b1, 1'b0));
                held_prog = mtsed_pkg::PROG_NONE;
                taken = 1;
            end else if (nxt != mtsed_pkg::PROG_NONE) begin
                held_prog = nxt;
                taken = 1;
            end else begin
                release_prefix();
            end
        end else begin
            held_prog = mtsed_pkg::PROG_NONE;
        end
        // the breaking byte (or a fresh one) is handled on its own
        if (!taken) begin
            if (it.in_byte == mtsed_pkg::C_LT)
                tag_open = 1'b1;
            else if (it.in_byte == mtsed_pkg::C_GT)
                tag_open = 1'b0;
            else if (it.in_byte == mtsed_pkg::C_AMP)
                held_prog = mtsed_pkg::PROG_AMP;
            else if (!tag_open)
                step_res.push_back(make_result(it.in_byte, 1'b1, 1'b0));
        end
        if (it.end_of_message) begin
            release_prefix();
            if (step_res.size() > 0) begin
                // mark the last byte result; no separate marker follows
                tail = step_res.pop_back();
                tail.last_of_message = 1'b1;
                step_res.push_back(tail);
            end else begin
                step_res.push_back(make_result(8'h00, 1'b0, 1'b1));
            end
            tag_open  = 1'b0;
            held_prog = mtsed_pkg::PROG_NONE;
        end
        foreach (step_res[i])
            text_due.push_back(step_res[i]);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random back-pressure, and the result checker
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // Compare each accepted result with the oldest one due
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (text_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected result: byte %02h has %0d last %0d",
                             o_out_item.out_byte, o_out_item.has_byte,
                             o_out_item.last_of_message);
            end else begin
                want = text_due.pop_front();
                if (o_out_item.out_byte !== want.out_byte ||
                    o_out_item.has_byte !== want.has_byte ||
                    o_out_item.last_of_message !== want.last_of_message) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("mismatch at result %0d: exp byte %02h has %0d last %0d, ",
                                 results_seen, want.out_byte, want.has_byte,
                                 want.last_of_message,
                                 "got byte %02h has %0d last %0d",
                                 o_out_item.out_byte, o_out_item.has_byte,
                                 o_out_item.last_of_message);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    // Called just after a rising edge. Idle at random, then hold valid and
    // the item until accepted. Valid stays high on return, so a back-to-back
    // item needs no extra edge; the next call or a drain lowers it.
    task automatic send_item(mtsed_pkg::t_in_item it);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
        if (it.end_of_message)
            messages_sent++;
        strip_decode_item(it);
    endtask

    task automatic send_text(string s, bit end_flag);
        int k;
        for (k = 0; k < s.len(); k++)
            send_item(make_item(s[k], end_flag && (k == s.len() - 1)));
    endtask

    // Drop valid and hold off until every due result has come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (text_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_SLACK) @(posedge i_clk);
    endtask

    function automatic string pick_entity();
        case ($urandom_range(0, 2))
            0:       return "&lt;";
            1:       return "&gt;";
            default: return "&amp;";
        endcase
    endfunction

    // Build one message from random fragments and send it, end flag on the
    // final byte. Most fragments are well formed; the rest are broken
    // entities, stray brackets and raw bytes.
    task automatic send_random_message();
        logic [7:0] msg[$];
        string      ent;
        int         n_frag, f, k, n;
        n_frag = int'($urandom_range(1, 6));
        for (f = 0; f < n_frag; f++) begin
            case ($urandom_range(0, 9))
                0, 1: msg.push_back(8'($urandom_range(0, 255)));
                2, 3: begin
                    ent = pick_entity();
                    for (k = 0; k < ent.len(); k++)
                        msg.push_back(ent[k]);
                end
                4: begin
                    // broken entity: a proper prefix, then a random byte
                    ent = pick_entity();
                    n = int'($urandom_range(1, ent.len() - 1));
                    for (k = 0; k < n; k++)
                        msg.push_back(ent[k]);
                    if ($urandom_range(0, 1))
                        msg.push_back(8'($urandom_range(0, 255)));
                    else
                        msg.push_back(8'("a" + $urandom_range(0, 25)));
                end
                5, 6: begin
                    // tag with a few letters and maybe an entity inside
                    msg.push_back(mtsed_pkg::C_LT);
                    n = int'($urandom_range(0, 3));
                    for (k = 0; k < n; k++)
                        msg.push_back(8'("a" + $urandom_range(0, 25)));
                    if ($urandom_range(0, 2) == 0) begin
                        ent = pick_entity();
                        for (k = 0; k < ent.len(); k++)
                            msg.push_back(ent[k]);
                    end
                    msg.push_back(mtsed_pkg::C_GT);
                end
                7: begin
                    case ($urandom_range(0, 2))
                        0:       msg.push_back(mtsed_pkg::C_LT);
                        1:       msg.push_back(mtsed_pkg::C_GT);
                        default: msg.push_back(mtsed_pkg::C_AMP);
                    endcase
                end
                default: begin
                    n = int'($urandom_range(1, 4));
                    for (k = 0; k < n; k++)
                        msg.push_back(8'("a" + $urandom_range(0, 25)));
                end
            endcase
        end
        for (k = 0; k < msg.size(); k++)
            send_item(make_item(msg[k], k == msg.size() - 1));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Lowest and highest byte values pass through as text
    task automatic test_byte_extremes();
        send_item(make_item(8'h00, 1'b0));
        send_item(make_item(8'hFF, 1'b1));
    endtask

    // Entity decoded inside a tag; end on a closing bracket gives a bare marker
    task automatic test_tag_entity();
        send_text("<&gt;>", 1'b1);
    endtask

    // Full entity, then "&amp" broken by a letter: five results from one item
    task automatic test_entity_release();
        send_text("&lt;&ampZ", 1'b1);
    endtask

    // Prefix broken by a bracket, prefix dropped inside a tag, end with text
    task automatic test_broken_in_tag();
        send_text("&l<&a>y", 1'b1);
    endtask

    // Unfinished entity flushed as text at message end
    task automatic test_unfinished_end();
        send_text("&am", 1'b1);
    endtask

    // Hold an entity prefix across a full drain, then finish it
    task automatic test_drain_pause();
        send_text("x&amp", 1'b0);
        wait_drained();
        send_text(";y", 1'b1);
    endtask

    task automatic test_random_messages(int src_pct, int sink_pct, int n_items);
        int start;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        start = items_sent;
        while (items_sent - start < n_items)
            send_random_message();
    endtask

    initial begin
        // synchronous reset, once
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_idle_pct  = 27;
        sink_idle_pct = 77;
        test_byte_extremes();
        test_tag_entity();
        test_entity_release();
        test_broken_in_tag();
        test_unfinished_end();

        test_random_messages(27, 77, N_PHASE);
        test_drain_pause();
        test_random_messages(77, 27, N_PHASE);
        test_random_messages(0, 0, N_PHASE);

        wait_drained();

        $display("Covered %0d items in %0d messages, %0d results checked.",
                 items_sent, messages_sent, results_seen);
        $display("Idle mixes: sender-light/receiver-heavy, reversed, none; one full drain.");
        if (mismatches == 0 && text_due.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches, %0d results still due", mismatches, text_due.size());
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
